@@ rtl/core/image_chunk_reassembler_defines.svh @@
// Assertion macros for the image chunk reassembler.
`ifndef IMAGE_CHUNK_REASSEMBLER_DEFINES_SVH
`define IMAGE_CHUNK_REASSEMBLER_DEFINES_SVH
`ifndef SYNTHESIS
`define ICR_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define ICR_ASSERT_NXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define ICR_ASSERT_IMP(label, clk, rst_n, a, b, msg)
`define ICR_ASSERT_NXT(label, clk, rst_n, a, b, msg)
`endif
`endif

@@ rtl/core/icr_pkg.sv @@
// ----------------------------------------------------------------------------
// icr_pkg
// Types and codes shared by the image chunk reassembler modules.
// ----------------------------------------------------------------------------
package icr_pkg;
	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_SKIP    = 2'd2,
		PH_CLOSE   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		HS_ILEAD = 3'd0,
		HS_IDIG  = 3'd1,
		HS_WAIT  = 3'd2,
		HS_TLEAD = 3'd3,
		HS_TDIG  = 3'd4,
		HS_TDONE = 3'd5,
		HS_DEAD  = 3'd7
	} hstep_t;

	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [15:0] CAP_RESET = 16'd20000;

	// One finished result item.
	typedef struct packed {
		logic        write_valid;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic        image_done;
		logic [15:0] image_length;
	} result_t;
endpackage

@@ rtl/core/icr_front.sv @@
// ----------------------------------------------------------------------------
// icr_front
// Parses packet headers, tracks chunk order and produces one result per byte.
// ----------------------------------------------------------------------------
module icr_front #(
	parameter int HEADER_LIMIT = 20,
	parameter int MAX_PACKET = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic [9:0]            packet_length,
	input  logic                  consumer_lock,
	input  logic [15:0]           capacity,
	output icr_pkg::result_t      result
);
	import icr_pkg::*;

	localparam int PW = $clog2(MAX_PACKET + 1);
	localparam int LW = (PW > 10) ? PW : 10;

	logic [PW-1:0] pos_q;
	phase_t        phase_q;
	hstep_t        hs_q;
	logic [16:0]   idx_q, tot_q;
	logic [1:0]    neg_q;
	logic [15:0]   count_q;
	logic [17:0]   exp_q;
	logic          acc_q;
	logic [15:0]   woff_q;

	logic [PW-1:0] pos_n;
	phase_t        phase_n;
	hstep_t        hs_n;
	logic [16:0]   idx_n, tot_n;
	logic [1:0]    neg_n;
	logic [15:0]   count_n;
	logic [17:0]   exp_n;
	logic          acc_n;
	logic [15:0]   woff_n;

	logic [LW-1:0] eff;
	logic          last, digit, space;
	logic [16:0]   plen;
	logic [17:0]   idx_s, tot_s;

	function automatic logic [16:0] accum(input logic [16:0] v, input logic [7:0] c);
		logic [20:0] n;
		n = 21'(v) * 21'd10 + 21'(c - 8'd48);
		return (n > 21'd65535) ? 17'd65535 : n[16:0];
	endfunction

	// Effective length, end of packet and character classes.
	always_comb begin
		eff = LW'(packet_length);
		if (packet_length == 10'd0) eff = LW'(1);
		if (eff > LW'(MAX_PACKET)) eff = LW'(MAX_PACKET);
		last = (LW'(pos_q) + LW'(1)) >= eff;
		digit = (data_byte >= 8'd48) && (data_byte <= 8'd57);
		space = (data_byte == 8'd32) || ((data_byte >= 8'd9) && (data_byte <= 8'd13));
		plen = (eff > LW'(pos_q) + LW'(1)) ? 17'(eff - LW'(pos_q) - LW'(1)) : 17'd0;
		idx_s = neg_q[0] ? -{1'b0, idx_q} : {1'b0, idx_q};
		tot_s = neg_q[1] ? -{1'b0, tot_q} : {1'b0, tot_q};
	end

	// Next-state and result logic for one byte.
	always_comb begin
		pos_n = pos_q; phase_n = phase_q; hs_n = hs_q; idx_n = idx_q; tot_n = tot_q;
		neg_n = neg_q; count_n = count_q; exp_n = exp_q; acc_n = acc_q; woff_n = woff_q;
		result = '0;
		case (phase_q)
			PH_HEADER: begin
				if (32'(pos_q) >= HEADER_LIMIT) begin
					phase_n = PH_SKIP;
				end else if (data_byte == CH_COLON) begin
					if (hs_q == HS_ILEAD || hs_q == HS_IDIG || hs_q == HS_WAIT ||
							hs_q == HS_DEAD) begin
						phase_n = PH_SKIP;
					end else if (consumer_lock) begin
						if (idx_s == 18'd0) exp_n = '1;
						phase_n = PH_SKIP;
					end else if (idx_s != 18'd0 && idx_s != exp_q + 18'd1) begin
						count_n = '0;
						exp_n = '1;
						phase_n = PH_SKIP;
					end else begin
						logic [15:0] base;
						base = (idx_s == 18'd0) ? 16'd0 : count_q;
						exp_n = idx_s;
						if ({1'b0, base} + plen <= {1'b0, capacity}) begin
							acc_n = 1'b1;
							woff_n = base;
							count_n = 16'(base + plen[15:0]);
						end else begin
							acc_n = 1'b0;
							count_n = base;
						end
						phase_n = (idx_s == tot_s - 18'd1) ? PH_CLOSE : PH_PAYLOAD;
					end
				end else if (hs_q == HS_DEAD || hs_q == HS_TDONE) begin
					hs_n = hs_q;
				end else if (data_byte == 8'd0) begin
					hs_n = (hs_q == HS_ILEAD || hs_q == HS_IDIG || hs_q == HS_WAIT) ?
						HS_DEAD : HS_TDONE;
				end else begin
					case (hs_q)
						HS_ILEAD: begin
							if (space) hs_n = HS_ILEAD;
							else if (data_byte == CH_PLUS) hs_n = HS_IDIG;
							else if (data_byte == CH_MINUS) begin
								neg_n[0] = 1'b1; hs_n = HS_IDIG;
							end else if (digit) begin
								idx_n = accum(idx_q, data_byte); hs_n = HS_IDIG;
							end else hs_n = (data_byte == CH_SLASH) ? HS_TLEAD : HS_WAIT;
						end
						HS_IDIG: begin
							if (digit) idx_n = accum(idx_q, data_byte);
							else hs_n = (data_byte == CH_SLASH) ? HS_TLEAD : HS_WAIT;
						end
						HS_WAIT: begin
							if (data_byte == CH_SLASH) hs_n = HS_TLEAD;
						end
						HS_TLEAD: begin
							if (space) hs_n = HS_TLEAD;
							else if (data_byte == CH_PLUS) hs_n = HS_TDIG;
							else if (data_byte == CH_MINUS) begin
								neg_n[1] = 1'b1; hs_n = HS_TDIG;
							end else if (digit) begin
								tot_n = accum(tot_q, data_byte); hs_n = HS_TDIG;
							end else hs_n = HS_TDONE;
						end
						HS_TDIG: begin
							if (digit) tot_n = accum(tot_q, data_byte);
							else hs_n = HS_TDONE;
						end
						default: hs_n = HS_DEAD;
					endcase
				end
			end
			PH_PAYLOAD, PH_CLOSE: begin
				if (acc_q) begin
					result.write_valid = 1'b1;
					result.write_address = woff_q;
					result.write_data = data_byte;
					woff_n = woff_q + 16'd1;
				end
			end
			default: ;
		endcase
		if (last) begin
			if (phase_n == PH_CLOSE) begin
				result.image_done = 1'b1;
				result.image_length = count_n;
			end
			pos_n = '0; phase_n = PH_HEADER; hs_n = HS_ILEAD;
			idx_n = '0; tot_n = '0; neg_n = '0;
		end else begin
			pos_n = pos_q + PW'(1);
		end
	end

	// State registers, updated on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; phase_q <= PH_HEADER; hs_q <= HS_ILEAD; idx_q <= '0; tot_q <= '0;
			neg_q <= '0; count_q <= '0; exp_q <= '1; acc_q <= 1'b0; woff_q <= '0;
		end else if (step) begin
			pos_q <= pos_n; phase_q <= phase_n; hs_q <= hs_n; idx_q <= idx_n;
			tot_q <= tot_n; neg_q <= neg_n; count_q <= count_n; exp_q <= exp_n;
			acc_q <= acc_n; woff_q <= woff_n;
		end
	end
endmodule

@@ rtl/core/icr_queue.sv @@
// ----------------------------------------------------------------------------
// icr_queue
// Short result queue that parts the byte parser from the result consumer.
// ----------------------------------------------------------------------------
module icr_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  icr_pkg::result_t wdata,
	output logic             full,
	input  logic             rd,
	output logic             empty,
	output icr_pkg::result_t rdata
);
	import icr_pkg::*;

	localparam int AW = $clog2(DEPTH);

	result_t         mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	// Storage writes.
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + AW'(1);
			if (rd) rp_q <= (32'(rp_q) == DEPTH - 1) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

@@ rtl/core/image_chunk_reassembler.sv @@
// ----------------------------------------------------------------------------
// image_chunk_reassembler
// Reassembles numbered image chunks from notification packet bytes.
// ----------------------------------------------------------------------------
// One byte item is taken per cycle while full is low; each produces one result
// item, visible in the cycle after, held in a four-entry result queue. The parser
// computes all of its next state from each byte, so throughput is one item per clock
// as long as pop keeps up; full rises only when four results wait.
`include "image_chunk_reassembler_defines.svh"
module image_chunk_reassembler #(
	parameter int HEADER_LIMIT = 20,
	parameter int MAX_PACKET = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic [9:0]  packet_length,
	input  logic        consumer_lock,
	output logic        empty,
	input  logic        pop,
	output logic        write_valid,
	output logic [15:0] write_address,
	output logic [7:0]  write_data,
	output logic        image_done,
	output logic [15:0] image_length,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import icr_pkg::*;

	logic [15:0] cap_q;
	logic        step, deq;
	result_t     res, head;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= CAP_RESET;
		else if (cfg_we) cap_q <= cfg_wdata;
	end

	assign step = push && !full;
	assign deq  = pop && !empty;

	icr_front #(.HEADER_LIMIT(HEADER_LIMIT), .MAX_PACKET(MAX_PACKET)) u_front (
		.clk, .arst_n, .step, .data_byte, .packet_length, .consumer_lock,
		.capacity(cap_q), .result(res)
	);

	icr_queue #(.DEPTH(4)) u_queue (
		.clk, .arst_n, .wr(step), .wdata(res), .full, .rd(deq), .empty, .rdata(head)
	);

	assign write_valid   = head.write_valid;
	assign write_address = head.write_address;
	assign write_data    = head.write_data;
	assign image_done    = head.image_done;
	assign image_length  = head.image_length;

	// A result item becomes visible after an accepted byte when nothing drains.
	`ICR_ASSERT_NXT(a_push_shows, clk, arst_n, step && !deq, !empty, "result missing")
	`ICR_ASSERT_IMP(a_len_done, clk, arst_n, !empty && !image_done, image_length == 16'd0, "length without done")
	`ICR_ASSERT_IMP(a_addr_valid, clk, arst_n, !empty && !write_valid, write_address == 16'd0, "address without store")
endmodule
